// ===== sv/bfi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfi_pkg
// Types and constants shared by the byte run fault injector modules.
// ----------------------------------------------------------------------------
package bfi_pkg;

	localparam int CFG_W    = 17;
	localparam int ROW_BITS = 32;
	localparam int ROW_LOG  = 5;
	localparam int EPOCH_W  = 8;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_PLACE = 2'd1;
	localparam logic [1:0] OP_PASS  = 2'd2;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_PLACE = 2'd1;
	localparam logic [1:0] KIND_PASS  = 2'd2;

	localparam logic [1:0] PST_OK      = 2'd0;
	localparam logic [1:0] PST_OVERLAP = 2'd1;
	localparam logic [1:0] PST_RANGE   = 2'd2;
	localparam logic [1:0] PST_QUOTA   = 2'd3;

	localparam logic [1:0] REG_RUN_LENGTH    = 2'd0;
	localparam logic [1:0] REG_DROP_MODE     = 2'd1;
	localparam logic [1:0] REG_TARGET_RUNS   = 2'd2;
	localparam logic [1:0] REG_STREAM_LENGTH = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] run_start;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [1:0] place_status;
		logic [7:0] out_byte;
		logic [6:0] runs_placed;
	} out_item_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLR,
		S_PLACE,
		S_CHK_RD,
		S_CHK_EV,
		S_WR_RD,
		S_WR_WB,
		S_PASS,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic       load_item;
		logic       clear_state;
		logic       sweep_wr;
		logic       rd_en;
		logic       rd_pass;
		logic       place_init;
		logic       walk_adv;
		logic       wr_walk;
		logic       cnt_inc;
		logic       set_status;
		logic [1:0] place_code;
		logic       pass_eval;
		logic       load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic quota_fail;
		logic range_fail;
		logic hit;
		logic last_chunk;
		logic sweep_done;
		logic epoch_wrap;
		logic drop_now;
		logic out_free;
	} ctrl_sts_t;

endpackage
`default_nettype wire

// ===== sv/bfi_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfi_ctrl
// Sequencer: decodes items, walks placements row by row, runs clear sweeps.
// ----------------------------------------------------------------------------
module bfi_ctrl import bfi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  wire logic [1:0] opcode,
	input  wire ctrl_sts_t  sts,
	output ctrl_cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cmd.load_item = 1'b1;
					case (opcode)
						OP_CLEAR: begin
							cmd.clear_state = 1'b1;
							state_d = sts.epoch_wrap ? S_CLR : S_EMIT;
						end
						OP_PLACE: begin
							state_d = S_PLACE;
						end
						OP_PASS: begin
							cmd.rd_en   = 1'b1;
							cmd.rd_pass = 1'b1;
							state_d     = S_PASS;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_CLR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_done) begin
					state_d = S_EMIT;
				end
			end
			S_PLACE: begin
				if (sts.quota_fail) begin
					cmd.set_status = 1'b1;
					cmd.place_code = PST_QUOTA;
					state_d        = S_EMIT;
				end else if (sts.range_fail) begin
					cmd.set_status = 1'b1;
					cmd.place_code = PST_RANGE;
					state_d        = S_EMIT;
				end else begin
					cmd.place_init = 1'b1;
					state_d        = S_CHK_RD;
				end
			end
			S_CHK_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CHK_EV;
			end
			S_CHK_EV: begin
				if (sts.hit) begin
					cmd.set_status = 1'b1;
					cmd.place_code = PST_OVERLAP;
					state_d        = S_EMIT;
				end else if (sts.last_chunk) begin
					cmd.place_init = 1'b1;
					state_d        = S_WR_RD;
				end else begin
					cmd.walk_adv = 1'b1;
					state_d      = S_CHK_RD;
				end
			end
			S_WR_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_WR_WB;
			end
			S_WR_WB: begin
				cmd.wr_walk  = 1'b1;
				cmd.walk_adv = 1'b1;
				if (sts.last_chunk) begin
					cmd.cnt_inc    = 1'b1;
					cmd.set_status = 1'b1;
					cmd.place_code = PST_OK;
					state_d        = S_EMIT;
				end else begin
					state_d = S_WR_RD;
				end
			end
			S_PASS: begin
				cmd.pass_eval = 1'b1;
				state_d = sts.drop_now ? S_IDLE : S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/bfi_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfi_dpath
// Mark map memory with per-row epoch tags, counters, run walker, result register.
// ----------------------------------------------------------------------------
module bfi_dpath import bfi_pkg::*; #(
	parameter int MAX_BYTES = 65536
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [9:0]       run_length,
	input  wire logic             drop_mode,
	input  wire logic [6:0]       target_runs,
	input  wire logic [CFG_W-1:0] stream_length,
	input  wire in_item_t         cmd_item,
	input  wire ctrl_cmd_t        cmd,
	output ctrl_sts_t             sts,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output out_item_t             res_item
);

	localparam int POS_W   = $clog2(MAX_BYTES + 1);
	localparam int ROWS    = (MAX_BYTES + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_AW  = $clog2(ROWS);
	localparam int LIM_W   = (POS_W > CFG_W) ? POS_W : CFG_W;
	localparam int ENTRY_W = EPOCH_W + ROW_BITS;

	logic [ENTRY_W-1:0] mem_q [ROWS];
	logic [ENTRY_W-1:0] rd_q;

	in_item_t           item_q;
	logic [POS_W-1:0]   byte_pos_q;
	logic [6:0]         count_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [ROW_AW-1:0]  sweep_q;
	logic [POS_W-1:0]   cur_q;
	logic [9:0]         rem_q;
	logic [1:0]         status_q;
	logic               marked_q;
	logic               res_valid_q;
	out_item_t          res_q;

	logic [ROW_AW-1:0]   rd_addr, wr_addr, pass_row, cur_row;
	logic [ENTRY_W-1:0]  wr_data;
	logic                wr_en;
	logic [ROW_BITS-1:0] row_bits, lo_mask, mask;
	logic [ROW_BITS:0]   hi_full;
	logic [ROW_LOG-1:0]  off;
	logic [ROW_LOG:0]    room, top;
	logic [9:0]          n;
	logic                last;
	logic [LIM_W-1:0]    run_end, limit;
	logic                pos_ok, marked;
	logic [1:0]          kind;

	assign pass_row = byte_pos_q[ROW_AW+ROW_LOG-1:ROW_LOG];
	assign cur_row  = cur_q[ROW_AW+ROW_LOG-1:ROW_LOG];
	assign rd_addr  = cmd.rd_pass ? pass_row : cur_row;
	assign wr_en    = cmd.sweep_wr | cmd.wr_walk;
	assign wr_addr  = cmd.sweep_wr ? sweep_q : cur_row;

	assign row_bits = (rd_q[ENTRY_W-1 -: EPOCH_W] == epoch_q) ? rd_q[ROW_BITS-1:0] : '0;

	// chunk of the run that falls in the current row
	assign off     = cur_q[ROW_LOG-1:0];
	assign room    = (ROW_LOG+1)'(ROW_BITS) - {1'b0, off};
	assign last    = rem_q <= 10'(room);
	assign n       = last ? rem_q : 10'(room);
	assign top     = {1'b0, off} + n[ROW_LOG:0];
	assign hi_full = ({{ROW_BITS{1'b0}}, 1'b1} << top) - 1'b1;
	assign lo_mask = {ROW_BITS{1'b1}} << off;
	assign mask    = hi_full[ROW_BITS-1:0] & lo_mask;

	assign wr_data = cmd.sweep_wr ? '0 : {epoch_q, row_bits | mask};

	assign run_end = LIM_W'(item_q.run_start) + LIM_W'(run_length);
	assign limit   = (LIM_W'(stream_length) > LIM_W'(MAX_BYTES)) ?
	                 LIM_W'(MAX_BYTES) : LIM_W'(stream_length);

	assign pos_ok = byte_pos_q < POS_W'(MAX_BYTES);
	assign marked = pos_ok && row_bits[byte_pos_q[ROW_LOG-1:0]];

	always_comb begin
		sts            = '0;
		sts.quota_fail = count_q >= target_runs;
		sts.range_fail = (run_length == 10'd0) || (run_end > limit);
		sts.hit        = |(row_bits & mask);
		sts.last_chunk = last;
		sts.sweep_done = sweep_q == ROW_AW'(ROWS - 1);
		sts.epoch_wrap = &epoch_q;
		sts.drop_now   = marked && drop_mode;
		sts.out_free   = !res_valid_q || res_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= cmd_item;
		end
		if (cmd.place_init) begin
			cur_q <= POS_W'(item_q.run_start);
			rem_q <= run_length;
		end else if (cmd.walk_adv) begin
			cur_q <= cur_q + POS_W'(n);
			rem_q <= rem_q - n;
		end
		if (cmd.set_status) begin
			status_q <= cmd.place_code;
		end
		if (cmd.pass_eval) begin
			marked_q <= marked;
		end
	end

	always_comb begin
		case (item_q.opcode)
			OP_CLEAR: kind = KIND_CLEAR;
			OP_PLACE: kind = KIND_PLACE;
			default:  kind = KIND_PASS;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.result_kind  <= kind;
			res_q.place_status <= (kind == KIND_PLACE) ? status_q : PST_OK;
			res_q.out_byte     <= (kind == KIND_PASS && !marked_q) ? item_q.data_byte : 8'd0;
			res_q.runs_placed  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= '0;
			count_q     <= '0;
			epoch_q     <= '0;
			sweep_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_state) begin
				byte_pos_q <= '0;
				count_q    <= '0;
				epoch_q    <= epoch_q + 1'b1;
			end else begin
				if (cmd.pass_eval && pos_ok) begin
					byte_pos_q <= byte_pos_q + 1'b1;
				end
				if (cmd.cnt_inc) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.sweep_wr) begin
				sweep_q <= sts.sweep_done ? '0 : sweep_q + 1'b1;
			end
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule
`default_nettype wire

// ===== sv/byte_run_fault_injector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_run_fault_injector
// Marks runs of byte positions in a map and damages a byte stream with them.
// ----------------------------------------------------------------------------
// Items enter on cmd_valid/cmd_ready, results leave on res_valid/res_ready.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data); the
// user writes it only while the block is idle; the block does not enforce it.
// One item is worked at a time; the map is a single-port memory of 32-bit
// rows with a registered read, so each row touched is read before it is used.
//   pass:  accept with the row read, evaluate, then result load; a dropped
//          byte has no result load. place: rejected on quota or range
//          right after accept; otherwise a check pass (read, evaluate per
//          row), a read-modify-write pass (read, write per row), result load.
//   clear: accept, result load; every 256th clear also sweeps all MAX_BYTES/32 rows.
// After reset the block sweeps MAX_BYTES/32 rows (2048 by default) before
// cmd_ready first rises; configuration writes are taken during the sweep.
// A finished result sits in an output register; the next item is taken
// while it waits, and the block holds its following result until the
// receiver takes the previous one.
// ----------------------------------------------------------------------------
module byte_run_fault_injector import bfi_pkg::*; #(
	parameter int MAX_BYTES = 65536
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire in_item_t         cmd_item,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output out_item_t             res_item
);

	logic [9:0]       run_length_q;
	logic             drop_mode_q;
	logic [6:0]       target_runs_q;
	logic [CFG_W-1:0] stream_length_q;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q    <= 10'd1;
			drop_mode_q     <= 1'b0;
			target_runs_q   <= 7'd1;
			stream_length_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RUN_LENGTH:    run_length_q    <= cfg_data[9:0];
				REG_DROP_MODE:     drop_mode_q     <= cfg_data[0];
				REG_TARGET_RUNS:   target_runs_q   <= cfg_data[6:0];
				REG_STREAM_LENGTH: stream_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bfi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.opcode    (cmd_item.opcode),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfi_dpath #(
		.MAX_BYTES (MAX_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.run_length    (run_length_q),
		.drop_mode     (drop_mode_q),
		.target_runs   (target_runs_q),
		.stream_length (stream_length_q),
		.cmd_item      (cmd_item),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_item      (res_item)
	);

endmodule
`default_nettype wire

// ===== sim/byte_run_fault_injector_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_fault_injector_chk
// Watches the register port and both item channels of the fault injector.
// Keeps its own mark map, stream position and run count, works out the
// result of every accepted item and compares delivered results in order.
// ----------------------------------------------------------------------------
module byte_run_fault_injector_chk import bfi_pkg::*; #(
	parameter int MAX_BYTES = 65536
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             cmd_valid,
	input  wire logic             cmd_ready,
	input  wire in_item_t         cmd_item,
	input  wire logic             res_valid,
	input  wire logic             res_ready,
	input  wire out_item_t        res_item,
	output int                    mismatches,
	output int                    outstanding,
	output int                    results_seen,
	output int                    marked_hits
);

	bit [MAX_BYTES-1:0] marks;
	int                 stream_pos;
	bit [6:0]           placed;
	bit [9:0]           run_len;
	bit                 drop;
	bit [6:0]           target;
	bit [16:0]          stream_len;

	out_item_t owed_outputs[$];
	int        errs;
	int        seen;
	int        hits;

	task automatic predict_fault_output(input in_item_t it, output bit emit,
			output out_item_t res);
		int         limit;
		bit         hit;
		logic [1:0] st;
		emit = 1'b0;
		res  = '0;
		hit  = 1'b0;
		case (it.opcode)
		OP_CLEAR: begin
			marks           = '0;
			stream_pos      = 0;
			placed          = '0;
			res.result_kind = KIND_CLEAR;
			emit            = 1'b1;
		end
		OP_PLACE: begin
			limit = (int'(stream_len) > MAX_BYTES) ? MAX_BYTES : int'(stream_len);
			if (placed >= target)
				st = PST_QUOTA;
			else if (run_len == 0 || int'(it.run_start) + int'(run_len) > limit)
				st = PST_RANGE;
			else begin
				for (int p = 0; p < int'(run_len); p++)
					hit |= marks[int'(it.run_start) + p];
				if (hit)
					st = PST_OVERLAP;
				else begin
					for (int p = 0; p < int'(run_len); p++)
						marks[int'(it.run_start) + p] = 1'b1;
					placed = placed + 7'd1;
					st     = PST_OK;
				end
			end
			res.result_kind  = KIND_PLACE;
			res.place_status = st;
			res.runs_placed  = placed;
			emit             = 1'b1;
		end
		OP_PASS: begin
			if (stream_pos < MAX_BYTES) begin
				hit        = marks[stream_pos];
				stream_pos = stream_pos + 1;
			end
			if (hit)
				hits++;
			if (!(hit && drop)) begin
				res.result_kind = KIND_PASS;
				res.out_byte    = hit ? 8'h00 : it.data_byte;
				res.runs_placed = placed;
				emit            = 1'b1;
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		out_item_t got;
		bit        emit;
		if (!arst_n) begin
			marks      = '0;
			stream_pos = 0;
			placed     = '0;
			run_len    = 10'd1;
			drop       = 1'b0;
			target     = 7'd1;
			stream_len = '0;
			owed_outputs.delete();
			errs = 0;
			seen = 0;
			hits = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
				REG_RUN_LENGTH:    run_len    = cfg_data[9:0];
				REG_DROP_MODE:     drop       = cfg_data[0];
				REG_TARGET_RUNS:   target     = cfg_data[6:0];
				REG_STREAM_LENGTH: stream_len = cfg_data[16:0];
				default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				predict_fault_output(cmd_item, emit, want);
				if (emit)
					owed_outputs.push_back(want);
			end
			if (res_valid && res_ready) begin
				got = res_item;
				seen++;
				if (owed_outputs.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result with nothing outstanding: kind %0d status %0d byte %02h runs %0d",
							$time, got.result_kind, got.place_status, got.out_byte,
							got.runs_placed);
				end else begin
					want = owed_outputs.pop_front();
					if (got.result_kind !== want.result_kind
							|| got.place_status !== want.place_status
							|| got.out_byte !== want.out_byte
							|| got.runs_placed !== want.runs_placed) begin
						errs++;
						if (errs <= 10)
							$display("%0t: result %0d: want kind %0d status %0d byte %02h runs %0d",
								$time, seen, want.result_kind, want.place_status,
								want.out_byte, want.runs_placed,
								"; got kind %0d status %0d byte %02h runs %0d",
								got.result_kind, got.place_status, got.out_byte,
								got.runs_placed);
					end
				end
			end
		end
		mismatches   <= errs;
		outstanding  <= owed_outputs.size();
		results_seen <= seen;
		marked_hits  <= hits;
	end

endmodule

// ===== sim/byte_run_fault_injector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_fault_injector_tb
// Drives clear, place and pass items through the fault injector under
// several register settings and pacing patterns: directed corner items,
// random sessions, a long output hold-off, a clear storm past the epoch
// wrap and runs at both ends of the full-size map.
// ----------------------------------------------------------------------------
module byte_run_fault_injector_tb;
	import bfi_pkg::*;

	localparam int MAX_BYTES   = 65536;
	localparam int SETTLE      = 2600;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 3000000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [1:0]       cfg_index = REG_RUN_LENGTH;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             cmd_valid = 1'b0;
	logic             cmd_ready;
	in_item_t         cmd_item  = '0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	out_item_t        res_item;

	int mismatches;
	int outstanding;
	int results_seen;
	int marked_hits;

	int   idle_pct   = 0;
	int   stall_pct  = 0;
	logic hold_start = 1'b0;
	int   hold_left  = 0;
	int   cycles     = 0;
	int   cur_len    = 1;
	int   cur_stream = 0;
	int   n_items    = 0;
	int   n_clear    = 0;
	int   n_place    = 0;
	int   n_pass     = 0;
	int   n_unused   = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	byte_run_fault_injector #(.MAX_BYTES(MAX_BYTES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	byte_run_fault_injector_chk #(.MAX_BYTES(MAX_BYTES)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd_item     (cmd_item),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_item     (res_item),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.marked_hits  (marked_hits)
	);

	always @(posedge clk) begin
		if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
		res_ready <= (hold_start || hold_left != 0) ? 1'b0
			: ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [15:0] start,
			input logic [7:0] data);
		in_item_t it;
		in_item_t noise;
		it.opcode    = op;
		it.run_start = start;
		it.data_byte = data;
		while ($urandom_range(99) < idle_pct) begin
			noise.opcode    = 2'($urandom_range(3));
			noise.run_start = 16'($urandom);
			noise.data_byte = 8'($urandom);
			cmd_valid <= 1'b0;
			cmd_item  <= noise;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		case (op)
		OP_CLEAR: n_clear++;
		OP_PLACE: n_place++;
		OP_PASS:  n_pass++;
		default:  n_unused++;
		endcase
		if (op != 2'd3)
			n_items++;
	endtask

	task automatic await_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic quiesce();
		await_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_cfg(input int len, input int drop, input int target,
			input int stream);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_RUN_LENGTH;
		cfg_data  <= CFG_W'(len);
		@(posedge clk);
		cfg_index <= REG_DROP_MODE;
		cfg_data  <= CFG_W'(drop);
		@(posedge clk);
		cfg_index <= REG_TARGET_RUNS;
		cfg_data  <= CFG_W'(target);
		@(posedge clk);
		cfg_index <= REG_STREAM_LENGTH;
		cfg_data  <= CFG_W'(stream);
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		cur_len    = len;
		cur_stream = stream;
	endtask

	// mostly runs that fit, some straddling the stream end, some anywhere
	function automatic logic [15:0] pick_start();
		int lim;
		int r;
		lim = (cur_stream > MAX_BYTES) ? MAX_BYTES : cur_stream;
		r   = $urandom_range(99);
		if (r < 70 && cur_len > 0 && lim >= cur_len)
			return 16'($urandom_range(lim - cur_len));
		if (r < 85 && lim >= cur_len)
			return 16'(lim - cur_len + $urandom_range(3));
		return 16'($urandom);
	endfunction

	task automatic run_sessions(input int count);
		int first;
		int places;
		int passes;
		first = n_items;
		while (n_items - first < count) begin
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(4) != 0)
					push_item(OP_CLEAR, 16'($urandom), 8'($urandom));
				places = $urandom_range(5, 1);
				repeat (places) push_item(OP_PLACE, pick_start(), 8'($urandom));
				passes = $urandom_range(cur_stream < 36 ? cur_stream + 4 : 40);
				repeat (passes) push_item(OP_PASS, 16'($urandom), 8'($urandom));
			end else
				push_item(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
		end
	endtask

	task automatic run_phase(input int len, input int drop, input int target,
			input int stream, input int idle, input int stall, input int count);
		quiesce();
		apply_cfg(len, drop, target, stream);
		idle_pct  <= idle;
		stall_pct <= stall;
		run_sessions(count);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners: status order, run edges, marked bytes zeroed
		apply_cfg(4, 0, 3, 64);
		push_item(OP_PLACE, 16'd0, 8'h00);
		push_item(OP_PLACE, 16'd2, 8'hFF);
		push_item(OP_PLACE, 16'd61, 8'h00);
		push_item(OP_PLACE, 16'd60, 8'h00);
		push_item(OP_PLACE, 16'hFFFF, 8'h00);
		push_item(OP_PLACE, 16'd10, 8'h00);
		push_item(OP_PLACE, 16'd20, 8'h00);
		push_item(OP_PASS, 16'hFFFF, 8'hFF);
		push_item(OP_PASS, 16'h0000, 8'h00);
		repeat (8) push_item(OP_PASS, 16'($urandom), 8'($urandom));
		push_item(OP_PASS, 16'h0000, 8'hFF);
		push_item(OP_PASS, 16'hFFFF, 8'h00);
		push_item(2'd3, 16'hFFFF, 8'hFF);
		push_item(OP_CLEAR, 16'h0000, 8'h00);
		push_item(OP_PLACE, 16'd0, 8'h00);
		push_item(OP_PASS, 16'h0000, 8'hFF);

		// zero quota, then zero run length
		quiesce();
		apply_cfg(0, 0, 0, 65536);
		push_item(OP_PLACE, 16'd0, 8'h00);
		quiesce();
		apply_cfg(0, 0, 5, 65536);
		push_item(OP_PLACE, 16'd0, 8'h00);

		run_phase(3, 0, 6, 40, 0, 0, 35);
		run_phase(1, 1, 100, 24, 49, 0, 35);
		run_phase(7, 0, 2, 60, 0, 49, 35);
		run_phase(2, 1, 4, 20, 9, 9, 35);
		run_phase(512, 0, 3, 1600, 0, 0, 20);

		// output held off while items keep coming, then a full drain
		run_phase(5, 0, 8, 50, 0, 0, 0);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		run_sessions(20);
		await_results();
		run_sessions(30);

		// enough clears to wrap the clear epoch
		quiesce();
		apply_cfg(2, 1, 1, 8);
		idle_pct  <= 9;
		stall_pct <= 9;
		while (n_clear < 260) begin
			push_item(OP_CLEAR, 16'($urandom), 8'($urandom));
			if ($urandom_range(9) < 3)
				push_item(OP_PLACE, 16'($urandom_range(1)), 8'($urandom));
			if ($urandom_range(9) < 2)
				push_item(OP_PASS, 16'($urandom), 8'($urandom));
		end

		// whole map, runs at both ends, then the head of the stream
		quiesce();
		apply_cfg(512, 1, 2, MAX_BYTES);
		idle_pct  <= 0;
		stall_pct <= 0;
		push_item(OP_CLEAR, 16'h0000, 8'h00);
		push_item(OP_PLACE, 16'(MAX_BYTES - 512), 8'h00);
		push_item(OP_PLACE, 16'(MAX_BYTES - 511), 8'h00);
		push_item(OP_PLACE, 16'd0, 8'h00);
		push_item(OP_PLACE, 16'd10, 8'h00);
		repeat (40) push_item(OP_PASS, 16'($urandom), 8'($urandom));
		push_item(OP_CLEAR, 16'h0000, 8'h00);
		push_item(OP_PASS, 16'h0000, 8'hA5);

		run_phase(1, 0, 1, 0, 9, 9, 30);

		await_results();
		repeat (100) @(posedge clk);
		$display("items: %0d clears, %0d placements, %0d data bytes, %0d unused opcodes",
			n_clear, n_place, n_pass, n_unused);
		$display("results compared: %0d, data bytes on marked positions: %0d",
			results_seen, marked_hits);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
